// File: sv/spr_pkg.sv
package spr_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_STEPS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_DELAY   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_DELAY   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CREEP_DELAY  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LED_FULL     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LED_EDGE_EN  = 3'd5;

	// steps near either end of travel that use the edge enable value
	localparam int EDGE_STEPS = 50;

	typedef struct packed {
		logic want_middle;
		logic left_sensor;
		logic middle_sensor;
	} spr_in_t;

	typedef struct packed {
		logic       direction;
		logic       step_pulse;
		logic [7:0] led_level;
		logic       led_enable;
		logic       moving;
	} spr_out_t;

	// ramp divider control and status
	typedef struct packed {
		logic load_prod;
		logic init;
		logic iter;
	} spr_div_ctl_t;

	typedef struct packed {
		logic       busy;
		logic [7:0] quot;
	} spr_div_st_t;

	// microcode
	localparam int UPC_W = 4;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_FETCH,
		OP_IDLE_EVAL,
		OP_MUL,
		OP_DIV_INIT,
		OP_DIV_ITER,
		OP_STEP_EVAL,
		OP_STEP_END,
		OP_WAIT_DEC,
		OP_CREEP_DEC,
		OP_EMIT
	} spr_op_t;

	typedef enum logic [2:0] {
		COND_NONE,
		COND_ALWAYS,
		COND_PH_STEP,
		COND_PH_WAIT,
		COND_PH_CREEP,
		COND_DIV_BUSY,
		COND_I_GE_TOTAL
	} spr_cond_t;

	typedef struct packed {
		spr_op_t           op;
		spr_cond_t         cond;
		logic [UPC_W-1:0]  target;
	} spr_uword_t;

	localparam logic [UPC_W-1:0] UPC_FETCH     = 4'd0;
	localparam logic [UPC_W-1:0] UPC_DISP_STEP = 4'd1;
	localparam logic [UPC_W-1:0] UPC_DISP_WAIT = 4'd2;
	localparam logic [UPC_W-1:0] UPC_DISP_CRP  = 4'd3;
	localparam logic [UPC_W-1:0] UPC_IDLE      = 4'd4;
	localparam logic [UPC_W-1:0] UPC_MUL       = 4'd5;
	localparam logic [UPC_W-1:0] UPC_DIV_INIT  = 4'd6;
	localparam logic [UPC_W-1:0] UPC_DIV_ITER  = 4'd7;
	localparam logic [UPC_W-1:0] UPC_STEP_EVAL = 4'd8;
	localparam logic [UPC_W-1:0] UPC_STEP_END  = 4'd9;
	localparam logic [UPC_W-1:0] UPC_WAIT      = 4'd10;
	localparam logic [UPC_W-1:0] UPC_CREEP     = 4'd11;
	localparam logic [UPC_W-1:0] UPC_EMIT      = 4'd12;

	function automatic spr_uword_t spr_ucode(input logic [UPC_W-1:0] upc);
		spr_uword_t w;
		w = '{op: OP_NOP, cond: COND_ALWAYS, target: UPC_FETCH};
		unique case (upc)
			UPC_FETCH:     w = '{op: OP_FETCH,     cond: COND_NONE,       target: UPC_FETCH};
			UPC_DISP_STEP: w = '{op: OP_NOP,       cond: COND_PH_STEP,    target: UPC_MUL};
			UPC_DISP_WAIT: w = '{op: OP_NOP,       cond: COND_PH_WAIT,    target: UPC_WAIT};
			UPC_DISP_CRP:  w = '{op: OP_NOP,       cond: COND_PH_CREEP,   target: UPC_CREEP};
			UPC_IDLE:      w = '{op: OP_IDLE_EVAL, cond: COND_ALWAYS,     target: UPC_EMIT};
			UPC_MUL:       w = '{op: OP_MUL,       cond: COND_I_GE_TOTAL, target: UPC_STEP_END};
			UPC_DIV_INIT:  w = '{op: OP_DIV_INIT,  cond: COND_NONE,       target: UPC_FETCH};
			UPC_DIV_ITER:  w = '{op: OP_DIV_ITER,  cond: COND_DIV_BUSY,   target: UPC_DIV_ITER};
			UPC_STEP_EVAL: w = '{op: OP_STEP_EVAL, cond: COND_ALWAYS,     target: UPC_EMIT};
			UPC_STEP_END:  w = '{op: OP_STEP_END,  cond: COND_ALWAYS,     target: UPC_EMIT};
			UPC_WAIT:      w = '{op: OP_WAIT_DEC,  cond: COND_ALWAYS,     target: UPC_EMIT};
			UPC_CREEP:     w = '{op: OP_CREEP_DEC, cond: COND_ALWAYS,     target: UPC_EMIT};
			UPC_EMIT:      w = '{op: OP_EMIT,      cond: COND_ALWAYS,     target: UPC_FETCH};
			default:       w = '{op: OP_NOP,       cond: COND_ALWAYS,     target: UPC_FETCH};
		endcase
		return w;
	endfunction

endpackage

// File: sv/spr_if.sv
interface spr_in_if;
	import spr_pkg::*;

	logic    valid;
	logic    ready;
	spr_in_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface spr_out_if;
	import spr_pkg::*;

	logic     valid;
	logic     ready;
	spr_out_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: sv/spr_div.sv
module spr_div #(
	parameter int STEP_COUNT_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  spr_pkg::spr_div_ctl_t       ctl,
	input  logic [STEP_COUNT_BITS-1:0]  index,
	input  logic [7:0]                  full,
	input  logic [STEP_COUNT_BITS-1:0]  total,
	output spr_pkg::spr_div_st_t        st
);
	import spr_pkg::*;

	localparam int PW = STEP_COUNT_BITS + 8;

	logic [PW-1:0]              prod_q;
	logic [STEP_COUNT_BITS-1:0] rem_q;
	logic [7:0]                 quot_q;
	logic [2:0]                 cnt_q;
	logic                       busy_q;

	logic [7:0]                 prod_lo;
	logic [STEP_COUNT_BITS:0]   trial;
	logic                       fits;

	assign prod_lo = prod_q[7:0];
	assign trial   = {rem_q, prod_lo[cnt_q]};
	assign fits    = trial >= {1'b0, total};

	// index < total keeps the quotient within 8 bits, so the top part starts below total
	always_ff @(posedge clk) begin
		if (ctl.load_prod) begin
			prod_q <= PW'(index) * PW'(full);
		end
		if (ctl.init) begin
			rem_q <= prod_q[PW-1:8];
		end else if (ctl.iter) begin
			rem_q  <= fits ? STEP_COUNT_BITS'(trial - {1'b0, total})
			               : trial[STEP_COUNT_BITS-1:0];
			quot_q <= {quot_q[6:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 3'd0;
			busy_q <= 1'b0;
		end else if (ctl.init) begin
			cnt_q  <= 3'd7;
			busy_q <= 1'b1;
		end else if (ctl.iter) begin
			cnt_q  <= cnt_q - 3'd1;
			busy_q <= cnt_q != 3'd0;
		end
	end

	// busy asks for one more iteration after the current one
	assign st.busy = busy_q && (cnt_q != 3'd0);
	assign st.quot = quot_q;

	prop_iter_after_init: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.iter |-> busy_q)
		else $error("divider iterated without init");

	prop_cnt_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.init |=> cnt_q == 3'd7)
		else $error("divider count not loaded");

	prop_fits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.iter |-> rem_q < total)
		else $error("divider remainder out of range");

endmodule

// File: sv/stepper_position_ramp_controller.sv
// Stepper ramp controller: one input beat is one microsecond tick, and every tick gives
// exactly one status beat with the motor direction, pulse level, LED level and enable, and
// a moving flag. A microcode sequencer runs each tick through a fixed datapath: a wait
// tick, an idle or creep tick, and a step tick past the end of travel go from the fetch
// straight to their update and emit steps, while a step tick first runs the multiply and
// the 8-iteration restoring divider that forms the LED ramp
// step * led_full_level / travel. A status beat that is not taken stalls the sequencer
// only after the next input beat has been accepted. Configuration writes go through
// cfg_we / cfg_index / cfg_data and act at once; write them only while no tick is pending.
module stepper_position_ramp_controller #(
	parameter int STEP_COUNT_BITS = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [spr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [spr_pkg::CFG_DATA_W-1:0]   cfg_data,
	spr_in_if.sink                           tick,
	spr_out_if.source                        status
);
	import spr_pkg::*;

	localparam int SCB = STEP_COUNT_BITS;
	localparam int TW  = (SCB > 12) ? SCB : 12;
	localparam int CW  = ((SCB > 8) ? SCB : 8) + 1;

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_STEP  = 3'd1;
	localparam logic [2:0] PH_WAIT  = 3'd2;
	localparam logic [2:0] PH_CREEP = 3'd3;

	// configuration
	logic [11:0] travel_q, slow_q, fast_q, creep_q;
	logic [7:0]  full_q;
	logic        edge_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travel_q  <= 12'd1450;
			slow_q    <= 12'd700;
			fast_q    <= 12'd250;
			creep_q   <= 12'd750;
			full_q    <= 8'd245;
			edge_en_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TRAVEL_STEPS: travel_q  <= cfg_data;
				REG_SLOW_DELAY:   slow_q    <= cfg_data;
				REG_FAST_DELAY:   fast_q    <= cfg_data;
				REG_CREEP_DELAY:  creep_q   <= cfg_data;
				REG_LED_FULL:     full_q    <= cfg_data[7:0];
				REG_LED_EDGE_EN:  edge_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer and state
	logic [UPC_W-1:0] upc_q;
	logic [2:0]       phase_q;
	logic [SCB-1:0]   step_index_q;
	logic [11:0]      delay_q;
	logic             pulse_q, dir_q, enable_q;
	logic [7:0]       level_q;
	spr_in_t          tick_q;
	spr_out_t         out_q;
	logic             out_valid_q;

	spr_uword_t       uw;
	logic             take, stall;
	spr_div_ctl_t     div_ctl;
	spr_div_st_t      div_st;

	// datapath
	logic [TW-1:0]    travel_ext, cap_ext;
	logic [SCB-1:0]   total, half, mid_gap, idx_next;
	logic [TW-1:0]    dd;
	logic [11:0]      step_dly;
	logic [CW-1:0]    i_ext, total_ext, edge_ext;
	logic             at_left, at_mid, arrived, step_en;
	logic [7:0]       step_level;
	logic [11:0]      delay_dec;

	assign travel_ext = TW'(travel_q);
	assign cap_ext    = TW'((1 << SCB) - 1);
	assign total      = (travel_ext > cap_ext) ? SCB'(cap_ext) : SCB'(travel_ext);
	assign half       = total >> 1;
	assign mid_gap    = (half > step_index_q) ? half - step_index_q : step_index_q - half;
	assign idx_next   = step_index_q + SCB'(1);

	always_comb begin
		dd = TW'(mid_gap);
		if (dd > TW'(slow_q)) begin
			dd = TW'(slow_q);
		end
		if (dd < TW'(fast_q)) begin
			dd = TW'(fast_q);
		end
	end
	assign step_dly = dd[11:0];

	assign i_ext     = CW'(step_index_q);
	assign total_ext = CW'(total);
	assign edge_ext  = CW'(EDGE_STEPS);

	assign at_left    = !tick_q.left_sensor;
	assign at_mid     = !tick_q.middle_sensor;
	assign arrived    = dir_q ? at_mid : at_left;
	assign step_level = dir_q ? full_q - div_st.quot : div_st.quot;
	assign step_en    = dir_q ? ((i_ext + edge_ext > total_ext) ? edge_en_q : 1'b1)
	                          : ((i_ext < edge_ext) ? edge_en_q : 1'b1);
	assign delay_dec  = (delay_q != 12'd0) ? delay_q - 12'd1 : delay_q;

	assign uw = spr_ucode(upc_q);

	always_comb begin
		case (uw.cond)
			COND_ALWAYS:     take = 1'b1;
			COND_PH_STEP:    take = phase_q == PH_STEP;
			COND_PH_WAIT:    take = phase_q == PH_WAIT;
			COND_PH_CREEP:   take = phase_q == PH_CREEP;
			COND_DIV_BUSY:   take = div_st.busy;
			COND_I_GE_TOTAL: take = step_index_q >= total;
			default:         take = 1'b0;
		endcase
	end

	assign stall = ((uw.op == OP_FETCH) && !tick.valid) ||
	               ((uw.op == OP_EMIT) && out_valid_q && !status.ready);

	assign div_ctl.load_prod = uw.op == OP_MUL;
	assign div_ctl.init      = uw.op == OP_DIV_INIT;
	assign div_ctl.iter      = uw.op == OP_DIV_ITER;

	spr_div #(.STEP_COUNT_BITS(SCB)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.index  (step_index_q),
		.full   (full_q),
		.total  (total),
		.st     (div_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_FETCH;
		end else if (!stall) begin
			upc_q <= take ? uw.target : upc_q + UPC_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (uw.op == OP_FETCH && tick.valid) begin
			tick_q <= tick.data;
		end
		if (uw.op == OP_EMIT && !stall) begin
			out_q <= '{direction: dir_q, step_pulse: pulse_q, led_level: level_q,
			           led_enable: enable_q, moving: phase_q != PH_IDLE};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uw.op == OP_EMIT && !stall) begin
			out_valid_q <= 1'b1;
		end else if (status.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			step_index_q <= '0;
			delay_q      <= 12'd0;
			pulse_q      <= 1'b0;
			dir_q        <= 1'b0;
			level_q      <= 8'd0;
			enable_q     <= 1'b0;
		end else begin
			case (uw.op)
				OP_IDLE_EVAL: begin
					phase_q <= PH_IDLE;
					if ((!tick_q.want_middle && !at_left) || (tick_q.want_middle && !at_mid)) begin
						dir_q <= tick_q.want_middle;
						if (tick_q.want_middle ? at_left : at_mid) begin
							// known end stop: counted move
							level_q      <= tick_q.want_middle ? full_q : 8'd0;
							step_index_q <= '0;
							phase_q      <= (total == '0) ? PH_IDLE : PH_STEP;
						end else begin
							// position unknown: single creep step
							pulse_q <= !pulse_q;
							delay_q <= creep_q;
							phase_q <= (creep_q == 12'd0) ? PH_IDLE : PH_CREEP;
						end
					end else if (!tick_q.want_middle) begin
						level_q <= full_q;
					end else begin
						level_q  <= 8'd0;
						enable_q <= edge_en_q;
					end
				end
				OP_STEP_EVAL: begin
					level_q  <= step_level;
					enable_q <= step_en;
					if (arrived) begin
						phase_q <= PH_IDLE;
					end else begin
						pulse_q      <= !pulse_q;
						step_index_q <= idx_next;
						if (step_dly == 12'd0) begin
							phase_q <= (idx_next >= total) ? PH_IDLE : PH_STEP;
						end else begin
							delay_q <= step_dly;
							phase_q <= PH_WAIT;
						end
					end
				end
				OP_STEP_END: begin
					phase_q <= PH_IDLE;
				end
				OP_WAIT_DEC: begin
					delay_q <= delay_dec;
					if (delay_dec == 12'd0) begin
						phase_q <= (step_index_q >= total) ? PH_IDLE : PH_STEP;
					end
				end
				OP_CREEP_DEC: begin
					delay_q <= delay_dec;
					if (delay_dec == 12'd0) begin
						phase_q <= PH_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	assign tick.ready   = uw.op == OP_FETCH;
	assign status.valid = out_valid_q;
	assign status.data  = out_q;

	prop_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		tick.valid && tick.ready |=> !tick.ready)
		else $error("second tick taken before the first was evaluated");

	prop_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		uw.op == OP_STEP_EVAL |-> step_index_q < total)
		else $error("step evaluated past the end of travel");

	prop_ramp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		uw.op == OP_STEP_EVAL |-> div_st.quot <= full_q)
		else $error("led ramp exceeds full level");

	prop_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(uw.op == OP_EMIT))
		else $error("status beat raised outside emit step");

endmodule

// File: verif/tb_stepper_position_ramp_controller.sv
`timescale 1ns / 1ps

module tb_stepper_position_ramp_controller;
	import spr_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int NUM_PHASES  = 10;

	typedef enum logic [1:0] {MV_IDLE, MV_STEP, MV_WAIT, MV_CREEP} move_phase_t;
	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		spr_in_t               beat;
		logic                  fixed;
		spr_out_t              want;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	spr_in_if  tick_bus();
	spr_out_if status_bus();

	stepper_position_ramp_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.tick(tick_bus),
		.status(status_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register copies, reset values
	logic [11:0] travel    = 12'd1450;
	logic [11:0] slow_lim  = 12'd700;
	logic [11:0] fast_lim  = 12'd250;
	logic [11:0] creep_len = 12'd750;
	logic [7:0]  full_lvl  = 8'd245;
	logic        edge_en   = 1'b1;

	// motion state
	move_phase_t mv_ph      = MV_IDLE;
	logic [11:0] step_idx   = '0;
	logic [11:0] delay_left = '0;
	logic        pulse_q    = 1'b0;
	logic        dir_q      = 1'b0;
	logic [7:0]  lvl_q      = '0;
	logic        en_q       = 1'b0;

	spr_out_t status_due[$];
	spr_out_t due_beat;
	int       mismatches = 0;
	int       beats_seen = 0;
	int       cycles = 0;
	int       src_idle_pct = 0;
	int       sink_stall_pct = 0;
	logic     hold_active = 1'b0;
	event     hold_go;

	// simple carriage: position in steps from the left stop
	int       pos = 0;
	logic     want_q = 1'b0;

	function automatic int unsigned led_ramp(int unsigned i, int unsigned total);
		if (total == 0)
			return 0;
		return (i * full_lvl) / total;
	endfunction

	function automatic void begin_move(logic to_mid);
		dir_q = to_mid;
		lvl_q = to_mid ? full_lvl : 8'd0;
		step_idx = '0;
		mv_ph = (travel == 0) ? MV_IDLE : MV_STEP;
	endfunction

	function automatic void creep_one(logic to_mid);
		dir_q = to_mid;
		pulse_q = ~pulse_q;
		delay_left = creep_len;
		mv_ph = (creep_len == 0) ? MV_IDLE : MV_CREEP;
	endfunction

	// one microsecond tick of the controller, returns the status after it
	function automatic spr_out_t ramp_tick(spr_in_t d);
		logic want_mid, at_left, at_mid, arrived;
		int unsigned total, i, gap, half;
		spr_out_t r;
		want_mid = d.want_middle;
		at_left = !d.left_sensor;
		at_mid = !d.middle_sensor;
		total = 32'(travel);
		case (mv_ph)
			MV_STEP: begin
				i = 32'(step_idx);
				if (i >= total) begin
					mv_ph = MV_IDLE;
				end else begin
					if (dir_q) begin
						lvl_q = 8'(full_lvl - led_ramp(i, total));
						en_q = (i + EDGE_STEPS > total) ? edge_en : 1'b1;
						arrived = at_mid;
					end else begin
						lvl_q = 8'(led_ramp(i, total));
						en_q = (i < EDGE_STEPS) ? edge_en : 1'b1;
						arrived = at_left;
					end
					if (arrived) begin
						mv_ph = MV_IDLE;
					end else begin
						pulse_q = ~pulse_q;
						// distance from mid-travel, slow clamp first, fast clamp wins
						half = total / 2;
						gap = (half > i) ? half - i : i - half;
						if (gap > slow_lim)
							gap = 32'(slow_lim);
						if (gap < fast_lim)
							gap = 32'(fast_lim);
						step_idx = 12'(i + 1);
						if (gap == 0) begin
							mv_ph = (step_idx >= total) ? MV_IDLE : MV_STEP;
						end else begin
							delay_left = 12'(gap);
							mv_ph = MV_WAIT;
						end
					end
				end
			end
			MV_WAIT: begin
				if (delay_left != 0)
					delay_left = delay_left - 12'd1;
				if (delay_left == 0)
					mv_ph = (step_idx >= total) ? MV_IDLE : MV_STEP;
			end
			MV_CREEP: begin
				if (delay_left != 0)
					delay_left = delay_left - 12'd1;
				if (delay_left == 0)
					mv_ph = MV_IDLE;
			end
			default: begin
				mv_ph = MV_IDLE;
				if (!want_mid) begin
					if (!at_left) begin
						if (at_mid)
							begin_move(1'b0);
						else
							creep_one(1'b0);
					end else begin
						lvl_q = full_lvl;
					end
				end else begin
					if (!at_mid) begin
						if (at_left)
							begin_move(1'b1);
						else
							creep_one(1'b1);
					end else begin
						lvl_q = 8'd0;
						en_q = edge_en;
					end
				end
			end
		endcase
		r.direction = dir_q;
		r.step_pulse = pulse_q;
		r.led_level = lvl_q;
		r.led_enable = en_q;
		r.moving = (mv_ph != MV_IDLE);
		return r;
	endfunction

	function automatic plan_row_t tick_row(logic w, logic l, logic m);
		plan_row_t row;
		row.kind = ROW_TICK;
		row.beat = {w, l, m};
		row.fixed = 1'b0;
		row.want = '0;
		row.idx = REG_TRAVEL_STEPS;
		row.val = '0;
		return row;
	endfunction

	function automatic plan_row_t fixed_row(logic w, logic l, logic m, spr_out_t want);
		plan_row_t row;
		row = tick_row(w, l, m);
		row.fixed = 1'b1;
		row.want = want;
		return row;
	endfunction

	function automatic plan_row_t write_row(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] val);
		plan_row_t row;
		row = tick_row(1'b0, 1'b0, 1'b0);
		row.kind = ROW_WRITE;
		row.idx = idx;
		row.val = val;
		return row;
	endfunction

	task automatic flag_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
		$display("mismatch %s: got %0h want %0h at status beat %0d", what, got, want,
			beats_seen);
		mismatches++;
	endtask

	// stop offering and wait until every status beat is in
	task automatic settle();
		tick_bus.valid <= 1'b0;
		@(posedge clk);
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_TRAVEL_STEPS: travel = val;
			REG_SLOW_DELAY:   slow_lim = val;
			REG_FAST_DELAY:   fast_lim = val;
			REG_CREEP_DELAY:  creep_len = val;
			REG_LED_FULL:     full_lvl = val[7:0];
			REG_LED_EDGE_EN:  edge_en = val[0];
			default: ;
		endcase
		if (pos > travel)
			pos = int'(travel);
	endtask

	task automatic send_tick(input spr_in_t d, input logic fixed, input spr_out_t fixed_want);
		spr_out_t r;
		logic old_pulse;
		while ($urandom_range(99) < src_idle_pct) begin
			tick_bus.valid <= 1'b0;
			@(posedge clk);
		end
		tick_bus.valid <= 1'b1;
		tick_bus.data <= d;
		@(posedge clk);
		while (!tick_bus.ready)
			@(posedge clk);
		old_pulse = pulse_q;
		r = ramp_tick(d);
		status_due.push_back(fixed ? fixed_want : r);
		// every pulse edge moves the carriage one step
		if (r.step_pulse != old_pulse) begin
			if (r.direction) begin
				if (pos < travel)
					pos++;
			end else if (pos > 0) begin
				pos--;
			end
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_stepper_position_ramp_controller: done, errors");
			$finish;
		end
	end

	initial begin
		forever begin
			@(hold_go);
			hold_active <= 1'b1;
			repeat (400) @(posedge clk);
			hold_active <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (hold_active)
			status_bus.ready <= 1'b0;
		else
			status_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && status_bus.valid && status_bus.ready) begin
			if (status_due.size() == 0) begin
				flag_mismatch("status beat with nothing pending", 8'h0, 8'h0);
			end else begin
				due_beat = status_due.pop_front();
				if (status_bus.data.direction !== due_beat.direction)
					flag_mismatch("direction", 8'(status_bus.data.direction),
						8'(due_beat.direction));
				if (status_bus.data.step_pulse !== due_beat.step_pulse)
					flag_mismatch("step_pulse", 8'(status_bus.data.step_pulse),
						8'(due_beat.step_pulse));
				if (status_bus.data.led_level !== due_beat.led_level)
					flag_mismatch("led_level", status_bus.data.led_level, due_beat.led_level);
				if (status_bus.data.led_enable !== due_beat.led_enable)
					flag_mismatch("led_enable", 8'(status_bus.data.led_enable),
						8'(due_beat.led_enable));
				if (status_bus.data.moving !== due_beat.moving)
					flag_mismatch("moving", 8'(status_bus.data.moving), 8'(due_beat.moving));
			end
			beats_seen++;
		end
	end

	initial begin
		plan_row_t plan[$];
		spr_in_t beat;
		int unsigned ph_travel [NUM_PHASES] = '{24, 60, 4095, 1, 9, 70, 0, 0, 0, 2047};
		int unsigned ph_slow   [NUM_PHASES] = '{6, 0, 2, 4095, 0, 1, 0, 0, 0, 4095};
		int unsigned ph_fast   [NUM_PHASES] = '{1, 0, 2, 0, 3, 0, 0, 0, 0, 4095};
		int unsigned ph_creep  [NUM_PHASES] = '{2, 1, 0, 4, 5, 2, 0, 0, 0, 4095};
		int unsigned ph_full   [NUM_PHASES] = '{200, 255, 255, 3, 0, 128, 0, 0, 0, 1};
		int unsigned ph_edge   [NUM_PHASES] = '{0, 1, 0, 1, 1, 0, 0, 0, 0, 0};
		int unsigned ph_mode   [NUM_PHASES] = '{0, 1, 2, 3, 1, 0, 2, 3, 0, 2};
		int unsigned n_items;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tick_bus.valid = 1'b0;
		tick_bus.data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stops and contradictory sensors under reset settings
		plan.push_back(fixed_row(1'b0, 1'b0, 1'b1, {1'b0, 1'b0, 8'd245, 1'b0, 1'b0}));
		plan.push_back(fixed_row(1'b1, 1'b1, 1'b0, {1'b0, 1'b0, 8'd0, 1'b1, 1'b0}));
		plan.push_back(fixed_row(1'b1, 1'b0, 1'b0, {1'b0, 1'b0, 8'd0, 1'b1, 1'b0}));
		plan.push_back(fixed_row(1'b0, 1'b0, 1'b0, {1'b0, 1'b0, 8'd245, 1'b1, 1'b0}));
		// creep with no wait
		plan.push_back(write_row(REG_CREEP_DELAY, 12'd0));
		plan.push_back(fixed_row(1'b0, 1'b1, 1'b1, {1'b0, 1'b1, 8'd245, 1'b1, 1'b0}));
		plan.push_back(fixed_row(1'b1, 1'b1, 1'b1, {1'b1, 1'b0, 8'd245, 1'b1, 1'b0}));
		// empty travel
		plan.push_back(write_row(REG_TRAVEL_STEPS, 12'd0));
		plan.push_back(fixed_row(1'b1, 1'b0, 1'b1, {1'b1, 1'b0, 8'd245, 1'b1, 1'b0}));
		// back-to-back steps with no delay
		plan.push_back(write_row(REG_TRAVEL_STEPS, 12'd4));
		plan.push_back(write_row(REG_SLOW_DELAY, 12'd0));
		plan.push_back(write_row(REG_FAST_DELAY, 12'd0));
		plan.push_back(write_row(REG_LED_FULL, 12'd255));
		plan.push_back(write_row(REG_LED_EDGE_EN, 12'd0));
		plan.push_back(fixed_row(1'b1, 1'b0, 1'b1, {1'b1, 1'b0, 8'd255, 1'b1, 1'b1}));
		repeat (4) plan.push_back(tick_row(1'b1, 1'b1, 1'b1));
		plan.push_back(tick_row(1'b1, 1'b1, 1'b0));
		// travel shrunk under a running move
		plan.push_back(tick_row(1'b0, 1'b1, 1'b0));
		repeat (2) plan.push_back(tick_row(1'b0, 1'b1, 1'b1));
		plan.push_back(write_row(REG_TRAVEL_STEPS, 12'd1));
		plan.push_back(tick_row(1'b0, 1'b1, 1'b1));
		// delayed steps, early arrival, then a timed creep
		plan.push_back(write_row(REG_TRAVEL_STEPS, 12'd6));
		plan.push_back(write_row(REG_SLOW_DELAY, 12'd2));
		plan.push_back(write_row(REG_FAST_DELAY, 12'd1));
		plan.push_back(write_row(REG_CREEP_DELAY, 12'd3));
		plan.push_back(write_row(REG_LED_EDGE_EN, 12'd1));
		plan.push_back(tick_row(1'b1, 1'b0, 1'b1));
		repeat (3) plan.push_back(tick_row(1'b1, 1'b1, 1'b1));
		plan.push_back(tick_row(1'b1, 1'b1, 1'b0));
		repeat (3) plan.push_back(tick_row(1'b0, 1'b1, 1'b1));

		foreach (plan[k]) begin
			if (plan[k].kind == ROW_WRITE)
				write_reg(plan[k].idx, plan[k].val);
			else
				send_tick(plan[k].beat, plan[k].fixed, plan[k].want);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p >= 6 && p < NUM_PHASES - 1) begin
				ph_travel[p] = $urandom_range(100, 1);
				ph_slow[p] = $urandom_range(10);
				ph_fast[p] = $urandom_range(6);
				ph_creep[p] = $urandom_range(6);
				ph_full[p] = $urandom_range(255);
				ph_edge[p] = $urandom_range(1);
			end
			write_reg(REG_TRAVEL_STEPS, 12'(ph_travel[p]));
			write_reg(REG_SLOW_DELAY, 12'(ph_slow[p]));
			write_reg(REG_FAST_DELAY, 12'(ph_fast[p]));
			write_reg(REG_CREEP_DELAY, 12'(ph_creep[p]));
			write_reg(REG_LED_FULL, 12'(ph_full[p]));
			write_reg(REG_LED_EDGE_EN, 12'(ph_edge[p]));
			if ($urandom_range(3) == 0)
				pos = $urandom_range(travel);
			src_idle_pct = (ph_mode[p] == 1) ? 55 : (ph_mode[p] == 3) ? 22 : 0;
			sink_stall_pct <= (ph_mode[p] == 2) ? 55 : (ph_mode[p] == 3) ? 22 : 0;
			// receiver goes quiet for a while so the block backs up
			if (p == 5)
				-> hold_go;
			n_items = (p == NUM_PHASES - 1) ? 40 : 80;
			repeat (n_items) begin
				// flip the request mostly when parked, rarely mid-move
				if ($urandom_range(99) < ((mv_ph == MV_IDLE) ? 15 : 2))
					want_q = ~want_q;
				beat.want_middle = want_q;
				beat.left_sensor = (pos != 0);
				beat.middle_sensor = (pos < travel);
				if ($urandom_range(99) < 10)
					beat = spr_in_t'(3'($urandom_range(7)));
				send_tick(beat, 1'b0, '0);
			end
		end

		settle();
		if (mismatches == 0)
			$display("tb_stepper_position_ramp_controller: done, clean");
		else
			$display("tb_stepper_position_ramp_controller: done, errors");
		$finish;
	end

endmodule

// File: filelist.f
sv/spr_pkg.sv
sv/spr_if.sv
sv/spr_div.sv
sv/stepper_position_ramp_controller.sv
verif/tb_stepper_position_ramp_controller.sv
